// File: rtl/esc_pkg.sv
// shared constants, types and the month-length table for the epoch to calendar converter
`default_nettype none

package esc_pkg;

  localparam int SECS_W   = 32;
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;

  // bit-serial divider: dividend register and partial remainder
  localparam int DIV_W    = 32;
  localparam int REM_W    = 17;
  localparam int ITER_W   = $clog2(DIV_W + 1);

  // whole days since the epoch fit here for any 32-bit count
  localparam int DAYS_W   = 16;

  localparam int START_YEAR_DEF = 2000;
  localparam logic [YEAR_W-1:0] LAST_YEAR = YEAR_W'(2099);

  localparam logic [REM_W-1:0] SECS_PER_DAY  = REM_W'(86400);
  localparam logic [REM_W-1:0] SECS_PER_HOUR = REM_W'(3600);
  localparam logic [REM_W-1:0] SECS_PER_MIN  = REM_W'(60);

  // iteration counts of the three divisions, dividend left aligned
  localparam logic [ITER_W-1:0] DAY_ITERS  = ITER_W'(32);
  localparam logic [ITER_W-1:0] HOUR_ITERS = ITER_W'(17);
  localparam logic [ITER_W-1:0] MIN_ITERS  = ITER_W'(12);

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
  } esc_div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } esc_div_sts_t;

  typedef struct packed {
    logic done;
    logic range_err;
  } esc_walk_sts_t;

  // days in a month, february stretched in leap years
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
      4'd2:                                       len = leap ? DAY_W'(29) : DAY_W'(28);
      default:                                    len = DAY_W'(31);
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// File: rtl/esc_if.sv
// valid/ready channels for the seconds input and the calendar result
`default_nettype none

interface esc_in_if;
  import esc_pkg::*;

  logic              valid;
  logic              ready;
  logic [SECS_W-1:0] seconds_since_epoch;

  modport source (output valid, output seconds_since_epoch, input ready);
  modport sink   (input valid, input seconds_since_epoch, output ready);
endinterface

interface esc_out_if;
  import esc_pkg::*;

  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0]   day_of_month;
  logic [HOUR_W-1:0]  hour;
  logic [MIN_W-1:0]   minute;
  logic [SEC_W-1:0]   second;
  logic               range_error;

  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, output second, output range_error,
                  input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input hour, input minute, input second, input range_error,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/esc_serdiv.sv
// restoring divider, one quotient bit per cycle, dividend taken msb first
`default_nettype none

module esc_serdiv (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  esc_pkg::esc_div_ctl_t         ctl_i,
  input  logic [esc_pkg::DIV_W-1:0]     dividend_i,
  input  logic [esc_pkg::REM_W-1:0]     divisor_i,
  output esc_pkg::esc_div_sts_t         sts_o,
  output logic [esc_pkg::DIV_W-1:0]     quotient_o,
  output logic [esc_pkg::REM_W-1:0]     remainder_o
);
  import esc_pkg::*;

  logic [REM_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  sh_q, sh_d;
  logic [ITER_W-1:0] cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [REM_W:0]    trial;
  logic [REM_W:0]    diff;
  logic              ge;

  assign trial = {rem_q, sh_q[DIV_W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = trial >= {1'b0, divisor_i};

  always_comb begin
    rem_d  = rem_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      rem_d = '0;
      sh_d  = dividend_i;
      cnt_d = ctl_i.iters;
    end else if (cnt_q != '0) begin
      rem_d  = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      // quotient bits enter at the bottom as the dividend leaves the top
      sh_d   = {sh_q[DIV_W-2:0], ge};
      cnt_d  = cnt_q - ITER_W'(1);
      done_d = (cnt_q == ITER_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

  assign sts_o.busy  = (cnt_q != '0);
  assign sts_o.done  = done_q;
  assign quotient_o  = sh_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

// File: rtl/esc_datewalk.sv
// year then month subtraction, one year or one month per cycle
`default_nettype none

module esc_datewalk #(
  parameter int START_YEAR = esc_pkg::START_YEAR_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [esc_pkg::DAYS_W-1:0]   days_i,
  output esc_pkg::esc_walk_sts_t       sts_o,
  output logic [esc_pkg::YEAR_W-1:0]   year_o,
  output logic [esc_pkg::MONTH_W-1:0]  month_o,
  output logic [esc_pkg::DAY_W-1:0]    day_o
);
  import esc_pkg::*;

  localparam logic [1:0] W_IDLE  = 2'd0;
  localparam logic [1:0] W_YEAR  = 2'd1;
  localparam logic [1:0] W_MONTH = 2'd2;
  localparam logic [1:0] W_DONE  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [DAYS_W-1:0]  days_q, days_d;
  logic [YEAR_W-1:0]  year_q, year_d;
  logic [MONTH_W-1:0] month_q, month_d;
  logic               err_q, err_d;
  logic               leap;
  logic [8:0]         ylen;
  logic [DAY_W-1:0]   mlen;

  assign leap = (year_q[1:0] == 2'b00);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_len(month_q, leap);

  always_comb begin
    state_d = state_q;
    days_d  = days_q;
    year_d  = year_q;
    month_d = month_q;
    err_d   = err_q;
    if (start_i) begin
      state_d = W_YEAR;
      days_d  = days_i;
      year_d  = YEAR_W'(START_YEAR);
      month_d = MONTH_JAN;
      err_d   = 1'b0;
    end else begin
      unique case (state_q)
        W_YEAR: begin
          if (year_q > LAST_YEAR) begin
            err_d   = 1'b1;
            state_d = W_DONE;
          end else if (days_q < DAYS_W'(ylen)) begin
            state_d = W_MONTH;
          end else begin
            days_d = days_q - DAYS_W'(ylen);
            year_d = year_q + YEAR_W'(1);
          end
        end
        W_MONTH: begin
          if (days_q < DAYS_W'(mlen) || month_q >= MONTH_DEC) begin
            state_d = W_DONE;
          end else begin
            days_d  = days_q - DAYS_W'(mlen);
            month_d = month_q + MONTH_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    days_q  <= days_d;
    year_q  <= year_d;
    month_q <= month_d;
    err_q   <= err_d;
  end

  assign sts_o.done      = (state_q == W_DONE);
  assign sts_o.range_err = err_q;
  assign year_o          = year_q;
  assign month_o         = month_q;
  assign day_o           = days_q[DAY_W-1:0] + DAY_W'(1);

endmodule

`default_nettype wire

// File: rtl/epoch_seconds_to_calendar_top.sv
// epoch seconds to calendar date and time of day converter, top level
// sequence: bit-serial day division, then the year/month walk (one year or
//   month per cycle) beside the hour and minute divisions
// the time from input transaction to result varies with the walk length
// throughput: one transaction at a time, next after the result loads, plus any result stall
// reset: asynchronous active low, clears sequencer state and the output valid
`default_nettype none

module epoch_seconds_to_calendar_top #(
  parameter int START_YEAR = esc_pkg::START_YEAR_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  esc_in_if.sink    in_i,
  esc_out_if.source out_o
);
  import esc_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an input transaction
  localparam logic [2:0] S_DAY  = 3'd1;  // seconds / 86400
  localparam logic [2:0] S_HOUR = 3'd2;  // time of day / 3600
  localparam logic [2:0] S_MIN  = 3'd3;  // remainder / 60
  localparam logic [2:0] S_JOIN = 3'd4;  // wait for date walk and free output

  logic [2:0]          state_q, state_d;

  esc_div_ctl_t        div_ctl;
  esc_div_sts_t        div_sts;
  logic [DIV_W-1:0]    div_dividend;
  logic [REM_W-1:0]    div_divisor;
  logic [DIV_W-1:0]    div_quot;
  logic [REM_W-1:0]    div_rem;

  logic                walk_start;
  esc_walk_sts_t       walk_sts;
  logic [YEAR_W-1:0]   walk_year;
  logic [MONTH_W-1:0]  walk_month;
  logic [DAY_W-1:0]    walk_day;

  logic [HOUR_W-1:0]   hour_q, hour_d;

  logic                out_valid_q, out_valid_d;
  logic                out_load;
  logic [YEAR_W-1:0]   year_q;
  logic [MONTH_W-1:0]  month_q;
  logic [DAY_W-1:0]    day_q;
  logic [HOUR_W-1:0]   ohour_q;
  logic [MIN_W-1:0]    minute_q;
  logic [SEC_W-1:0]    second_q;
  logic                err_q;

  logic                in_fire;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // output register is free when empty or being drained this cycle
  assign out_load = (state_q == S_JOIN) && walk_sts.done && (!out_valid_q || out_o.ready);

  // divisor follows the phase the divider is working on
  always_comb begin
    unique case (state_q)
      S_HOUR:  div_divisor = SECS_PER_HOUR;
      S_MIN:   div_divisor = SECS_PER_MIN;
      default: div_divisor = SECS_PER_DAY;
    endcase
  end

  always_comb begin
    state_d        = state_q;
    hour_d         = hour_q;
    div_ctl.start  = 1'b0;
    div_ctl.iters  = DAY_ITERS;
    div_dividend   = in_i.seconds_since_epoch;
    walk_start     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          div_ctl.start = 1'b1;
          state_d       = S_DAY;
        end
      end
      S_DAY: begin
        if (div_sts.done) begin
          // days go to the date walk, time of day back into the divider
          walk_start    = 1'b1;
          div_ctl.start = 1'b1;
          div_ctl.iters = HOUR_ITERS;
          div_dividend  = {div_rem, {(DIV_W-REM_W){1'b0}}};
          state_d       = S_HOUR;
        end
      end
      S_HOUR: begin
        if (div_sts.done) begin
          hour_d        = div_quot[HOUR_W-1:0];
          div_ctl.start = 1'b1;
          div_ctl.iters = MIN_ITERS;
          div_dividend  = {div_rem[11:0], {(DIV_W-12){1'b0}}};
          state_d       = S_MIN;
        end
      end
      S_MIN: begin
        if (div_sts.done) begin
          state_d = S_JOIN;
        end
      end
      S_JOIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers; divider holds minute and second after its last step
  always_ff @(posedge clk_i) begin
    hour_q <= hour_d;
    if (out_load) begin
      err_q <= walk_sts.range_err;
      if (walk_sts.range_err) begin
        year_q   <= '0;
        month_q  <= '0;
        day_q    <= '0;
        ohour_q  <= '0;
        minute_q <= '0;
        second_q <= '0;
      end else begin
        year_q   <= walk_year;
        month_q  <= walk_month;
        day_q    <= walk_day;
        ohour_q  <= hour_q;
        minute_q <= div_quot[MIN_W-1:0];
        second_q <= div_rem[SEC_W-1:0];
      end
    end
  end

  esc_serdiv u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (div_ctl),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .sts_o       (div_sts),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  esc_datewalk #(
    .START_YEAR (START_YEAR)
  ) u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (walk_start),
    .days_i  (div_quot[DAYS_W-1:0]),
    .sts_o   (walk_sts),
    .year_o  (walk_year),
    .month_o (walk_month),
    .day_o   (walk_day)
  );

  assign out_o.valid        = out_valid_q;
  assign out_o.year         = year_q;
  assign out_o.month        = month_q;
  assign out_o.day_of_month = day_q;
  assign out_o.hour         = ohour_q;
  assign out_o.minute       = minute_q;
  assign out_o.second       = second_q;
  assign out_o.range_error  = err_q;

  // an accepted transaction always leaves idle
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_DAY)
    else $error("sequencer did not start the day division");

  // a flagged result carries a zero date
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.range_error |->
      out_o.year == '0 && out_o.month == '0 && out_o.day_of_month == '0)
    else $error("range error with nonzero date");

  // a good result has a month of 1 to 12, a nonzero day and a year no later than 2099
  a_date_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.range_error |->
      out_o.month >= MONTH_JAN && out_o.month <= MONTH_DEC &&
      out_o.day_of_month != '0 && out_o.year <= LAST_YEAR)
    else $error("date out of range");

  // time of day fields stay in range
  a_tod_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.hour < HOUR_W'(24) && out_o.minute < MIN_W'(60) &&
      out_o.second < SEC_W'(60))
    else $error("time of day out of range");

  // the divider is never restarted while it is still shifting
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider restarted mid division");

endmodule

`default_nettype wire

// File: verif/epoch_seconds_to_calendar_top_test.sv
// self-checking testbench for the epoch seconds to calendar converter
module epoch_seconds_to_calendar_top_test;
  import esc_pkg::*;

  localparam int unsigned SECS_IN_DAY  = 86400;
  localparam int unsigned FINAL_YEAR   = 2099;
  localparam int unsigned N_RANDOM     = 450;
  localparam int unsigned MAX_REPORTS  = 10;
  // covers every item at its slowest with the largest input gap and result stall,
  // several times over
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // a little over the longest conversion the block can take
  localparam int unsigned DRAIN_CYCLES = 200;

  // month lengths of a common year, february patched for leap years
  localparam int unsigned SPAN_OF_MONTH [1:12] =
    '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day_of_month;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic               range_error;
  } calendar_t;

  // an expected date together with the count it came from, for reporting
  typedef struct {
    logic [SECS_W-1:0] secs;
    calendar_t         cal;
  } dated_secs_t;

  logic clk_i;
  logic rst_ni;

  esc_in_if  in_if ();
  esc_out_if out_if ();

  epoch_seconds_to_calendar_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic [SECS_W-1:0] pending_secs [$];   // counts still to be sent
  dated_secs_t       awaited_dates [$];  // dates predicted for accepted counts, oldest first

  int unsigned cycle_cnt;
  int unsigned mismatch_cnt;
  bit          failed;
  bit          in_took;     // input transaction at the last rising edge
  bit          out_took;    // result transaction at the last rising edge
  int unsigned in_gap;
  int unsigned out_stall;
  bit          in_quiet;    // stretch with no gaps on the input side
  bit          out_quiet;   // stretch with no stalls on the result side

  // ---------------------------------------------------------------------------
  // calendar arithmetic
  // ---------------------------------------------------------------------------

  // every fourth year is leap, good through 2099
  function automatic bit is_leap_year(input int unsigned y);
    return (y % 4) == 0;
  endfunction

  function automatic int unsigned month_span(input int unsigned mo, input int unsigned y);
    if (mo == 2 && is_leap_year(y)) begin
      return 29;
    end
    return SPAN_OF_MONTH[mo];
  endfunction

  // expected converter output for one count
  function automatic calendar_t calendar_of(input logic [SECS_W-1:0] secs);
    calendar_t   cal;
    int unsigned days;
    int unsigned tod;
    int unsigned yr;
    int unsigned mo;
    days = secs / SECS_IN_DAY;
    tod  = secs % SECS_IN_DAY;
    yr   = START_YEAR_DEF;
    mo   = 1;
    cal  = '0;
    // peel off whole years
    while (yr <= FINAL_YEAR && days >= (is_leap_year(yr) ? 366 : 365)) begin
      days -= is_leap_year(yr) ? 366 : 365;
      yr++;
    end
    // past the end of 2099 only the flag is set
    if (yr > FINAL_YEAR) begin
      cal.range_error = 1'b1;
      return cal;
    end
    // then whole months, december takes whatever is left
    while (mo < 12 && days >= month_span(mo, yr)) begin
      days -= month_span(mo, yr);
      mo++;
    end
    cal.year         = YEAR_W'(yr);
    cal.month        = MONTH_W'(mo);
    cal.day_of_month = DAY_W'(days + 1);
    cal.hour         = HOUR_W'(tod / 3600);
    cal.minute       = MIN_W'((tod % 3600) / 60);
    cal.second       = SEC_W'(tod % 60);
    return cal;
  endfunction

  // seconds since the epoch of a given date and time, for building stimulus
  function automatic longint unsigned secs_at(input int unsigned y, input int unsigned mo,
                                              input int unsigned d, input int unsigned h,
                                              input int unsigned mi, input int unsigned s);
    longint unsigned days;
    days = 0;
    for (int unsigned yy = START_YEAR_DEF; yy < y; yy++) begin
      days += is_leap_year(yy) ? 366 : 365;
    end
    for (int unsigned mm = 1; mm < mo; mm++) begin
      days += month_span(mm, y);
    end
    days += d - 1;
    return days * SECS_IN_DAY + h * 3600 + mi * 60 + s;
  endfunction

  // ---------------------------------------------------------------------------
  // clock and reset
  // ---------------------------------------------------------------------------

  initial clk_i = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // reset held low from time zero and released on a falling edge, every input known from time zero
  initial begin
    rst_ni                    = 1'b0;
    in_if.valid               = 1'b0;
    in_if.seconds_since_epoch = '0;
    out_if.ready              = 1'b0;
    out_stall                 = $urandom_range(0, 7);
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // sampling at the rising edge: predict on input transactions, check results
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    dated_secs_t item;
    calendar_t   got;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL epoch_seconds_to_calendar_top");
      $finish;
    end else begin
      in_took  = in_if.valid && in_if.ready;
      out_took = out_if.valid && out_if.ready;

      if (in_took) begin
        item.secs = in_if.seconds_since_epoch;
        item.cal  = calendar_of(in_if.seconds_since_epoch);
        awaited_dates.push_back(item);
      end

      if (out_took) begin
        got.year         = out_if.year;
        got.month        = out_if.month;
        got.day_of_month = out_if.day_of_month;
        got.hour         = out_if.hour;
        got.minute       = out_if.minute;
        got.second       = out_if.second;
        got.range_error  = out_if.range_error;
        if (awaited_dates.size() == 0) begin
          // a result nobody asked for
          failed = 1'b1;
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("unexpected result %0d-%0d-%0d %0d:%0d:%0d err %0b",
                     got.year, got.month, got.day_of_month,
                     got.hour, got.minute, got.second, got.range_error);
          end
        end else begin
          item = awaited_dates.pop_front();
          if (got.year !== item.cal.year || got.month !== item.cal.month ||
              got.day_of_month !== item.cal.day_of_month || got.hour !== item.cal.hour ||
              got.minute !== item.cal.minute || got.second !== item.cal.second ||
              got.range_error !== item.cal.range_error) begin
            failed = 1'b1;
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS) begin
              $display("mismatch for %0d s: %s, %s", item.secs,
                       $sformatf("exp %0d-%0d-%0d %0d:%0d:%0d err %0b",
                                 item.cal.year, item.cal.month, item.cal.day_of_month,
                                 item.cal.hour, item.cal.minute, item.cal.second,
                                 item.cal.range_error),
                       $sformatf("got %0d-%0d-%0d %0d:%0d:%0d err %0b",
                                 got.year, got.month, got.day_of_month,
                                 got.hour, got.minute, got.second, got.range_error));
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input driver, falling edge: a random gap, possibly none, before each count
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    logic nxt_valid;
    nxt_valid = in_if.valid;
    if (!rst_ni) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_if.valid && in_took) begin
        nxt_valid = 1'b0;
        // now and then switch between gapped traffic and back to back traffic
        if ($urandom_range(0, 31) == 0) begin
          in_quiet = !in_quiet;
        end
        in_gap = in_quiet ? 0 : $urandom_range(0, 7);
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_secs.size() != 0) begin
          in_if.seconds_since_epoch <= pending_secs.pop_front();
          nxt_valid = 1'b1;
        end
      end
    end
    // single update per edge so valid stays high across back to back transactions
    in_if.valid <= nxt_valid;
  end

  // ---------------------------------------------------------------------------
  // result sink, falling edge: ready held low for a random stall once a result shows up
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_took) begin
        if ($urandom_range(0, 31) == 0) begin
          out_quiet = !out_quiet;
        end
        out_stall = out_quiet ? 0 : $urandom_range(0, 7);
      end
      if (out_stall > 0) begin
        // the stall only runs down while a result is actually waiting
        if (out_if.valid) begin
          out_stall--;
        end
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    longint unsigned s;
    int unsigned     y;
    int unsigned     mo;
    int unsigned     pick;

    // directed: day, month and year edges, leap february, end of range, odd bit patterns
    pending_secs.push_back(32'd0);
    pending_secs.push_back(32'd59);
    pending_secs.push_back(32'd3599);
    pending_secs.push_back(32'd86399);
    pending_secs.push_back(32'd86400);
    pending_secs.push_back(SECS_W'(secs_at(2000, 2, 29, 23, 59, 59)));   // leap day
    pending_secs.push_back(SECS_W'(secs_at(2000, 3, 1, 0, 0, 0)));
    pending_secs.push_back(SECS_W'(secs_at(2001, 2, 28, 12, 34, 56)));   // common february end
    pending_secs.push_back(SECS_W'(secs_at(2001, 3, 1, 0, 0, 0)));
    // last second of a leap year
    pending_secs.push_back(SECS_W'(secs_at(2000, 12, 31, 23, 59, 59)));
    pending_secs.push_back(SECS_W'(secs_at(2001, 1, 1, 0, 0, 0)));
    // last day of a common year
    pending_secs.push_back(SECS_W'(secs_at(2001, 12, 31, 23, 59, 59)));
    pending_secs.push_back(SECS_W'(secs_at(2096, 12, 31, 0, 0, 0)));
    pending_secs.push_back(SECS_W'(secs_at(2050, 6, 30, 18, 0, 0)));
    pending_secs.push_back(SECS_W'(secs_at(2023, 11, 30, 7, 45, 30)));
    // last representable second, then the first one out of range
    pending_secs.push_back(SECS_W'(secs_at(2099, 12, 31, 23, 59, 59)));
    pending_secs.push_back(SECS_W'(secs_at(2100, 1, 1, 0, 0, 0)));
    pending_secs.push_back(32'hFFFF_FFFF);
    pending_secs.push_back(32'h8000_0000);
    pending_secs.push_back(32'h7FFF_FFFF);
    pending_secs.push_back(32'hAAAA_AAAA);
    pending_secs.push_back(32'h5555_5555);

    // random: mostly dates in range, a share hugging month starts, some full 32-bit counts
    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        s = $urandom;
      end else if (pick < 5) begin
        y  = $urandom_range(START_YEAR_DEF, FINAL_YEAR);
        mo = $urandom_range(1, 12);
        s  = secs_at(y, mo, 1, 0, 0, 0) + $urandom_range(0, 4) * SECS_IN_DAY;
        case ($urandom_range(0, 2))
          0:       s += 0;
          1:       s += SECS_IN_DAY - 1;
          default: s += $urandom_range(0, SECS_IN_DAY - 1);
        endcase
        // centre the window on the month start
        s = (s >= 2 * SECS_IN_DAY) ? s - 2 * SECS_IN_DAY : s;
      end else begin
        s = $urandom_range(0, 32'd3155759999);
      end
      pending_secs.push_back(SECS_W'(s));
    end

    // drain: everything sent, every result back, then a quiet tail for strays
    while (pending_secs.size() != 0 || in_if.valid || awaited_dates.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (awaited_dates.size() != 0) begin
      failed = 1'b1;
    end

    if (!failed) begin
      $display("PASS epoch_seconds_to_calendar_top");
    end else begin
      $display("FAIL epoch_seconds_to_calendar_top");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/esc_pkg.sv
rtl/esc_if.sv
rtl/esc_serdiv.sv
rtl/esc_datewalk.sv
rtl/epoch_seconds_to_calendar_top.sv
verif/epoch_seconds_to_calendar_top_test.sv
